### rtl/core/tid_pkg.sv
// Shared types, constants and register codes of the thresholded input debouncer.
package tid_pkg;

	localparam int SAMPLE_WIDTH_DEF = 12;
	localparam int COUNT_WIDTH_DEF  = 16;

	localparam int MODE_W     = 2;
	localparam int THR_W      = 12;
	localparam int DWELL_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [MODE_W-1:0]  MODE_SINGLE    = 2'd0;
	localparam logic [MODE_W-1:0]  MODE_DUAL      = 2'd1;
	localparam logic [MODE_W-1:0]  MODE_RESET     = MODE_SINGLE;
	localparam logic [THR_W-1:0]   THR_RESET      = 12'd2048;
	localparam logic [DWELL_W-1:0] LOW_DWELL_RST  = 16'd10;
	localparam logic [DWELL_W-1:0] HIGH_DWELL_RST = 16'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_MODE = 2'd0,
		REG_THRESHOLD  = 2'd1,
		REG_LOW_DWELL  = 2'd2,
		REG_HIGH_DWELL = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [MODE_W-1:0]  input_mode;
		logic [THR_W-1:0]   threshold;
		logic [DWELL_W-1:0] low_dwell;
		logic [DWELL_W-1:0] high_dwell;
	} tid_cfg_t;

endpackage

### rtl/core/tid_if.sv
// Channel interfaces of the debouncer: sample input, result output and configuration writes.
interface tid_sample_if #(parameter int SAMPLE_WIDTH = tid_pkg::SAMPLE_WIDTH_DEF);
	logic                    valid;
	logic                    ready;
	logic [SAMPLE_WIDTH-1:0] sample_a;
	logic [SAMPLE_WIDTH-1:0] sample_b;

	modport source (output valid, output sample_a, output sample_b, input ready);
	modport sink (input valid, input sample_a, input sample_b, output ready);
endinterface

interface tid_result_if;
	logic valid;
	logic ready;
	logic level;
	logic previous_level;
	logic changed;

	modport source (output valid, output level, output previous_level, output changed,
		input ready);
	modport sink (input valid, input level, input previous_level, input changed,
		output ready);
endinterface

interface tid_cfg_if;
	import tid_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/tid_cfg_regs.sv
// Configuration register file of the debouncer.
module tid_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	tid_cfg_if.sink          cfg,
	output tid_pkg::tid_cfg_t regs
);
	import tid_pkg::*;

	tid_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.input_mode <= MODE_RESET;
			regs_q.threshold  <= THR_RESET;
			regs_q.low_dwell  <= LOW_DWELL_RST;
			regs_q.high_dwell <= HIGH_DWELL_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_INPUT_MODE: regs_q.input_mode <= cfg.data[MODE_W-1:0];
				REG_THRESHOLD:  regs_q.threshold  <= cfg.data[THR_W-1:0];
				REG_LOW_DWELL:  regs_q.low_dwell  <= cfg.data[DWELL_W-1:0];
				REG_HIGH_DWELL: regs_q.high_dwell <= cfg.data[DWELL_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/tid_in_reg.sv
// Input register stage that captures one sample transfer.
module tid_in_reg #(
	parameter int SAMPLE_WIDTH = tid_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	tid_sample_if.sink              samples,
	input  logic                    take,
	output logic                    valid_s1,
	output logic [SAMPLE_WIDTH-1:0] sample_a_s1,
	output logic [SAMPLE_WIDTH-1:0] sample_b_s1
);
	import tid_pkg::*;

	assign samples.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_a_s1 <= samples.sample_a;
			sample_b_s1 <= samples.sample_b;
		end
	end

endmodule

### rtl/core/tid_debounce.sv
// Threshold compare, debounce state update and result register.
module tid_debounce #(
	parameter int SAMPLE_WIDTH = tid_pkg::SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = tid_pkg::COUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tid_pkg::tid_cfg_t       regs,
	input  logic                    valid_s1,
	input  logic [SAMPLE_WIDTH-1:0] sample_a_s1,
	input  logic [SAMPLE_WIDTH-1:0] sample_b_s1,
	output logic                    take,
	tid_result_if.source            results
);
	import tid_pkg::*;

	localparam int CMP_W = (SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W;
	localparam int DCMP_W = (COUNT_WIDTH > DWELL_W) ? COUNT_WIDTH : DWELL_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic                   started_q;
	logic                   last_raw_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   accepted_q;
	logic                   accepted_before_q;

	logic                   started_d;
	logic                   last_raw_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   accepted_d;
	logic                   accepted_before_d;
	logic                   changed_d;

	logic                   res_valid_q;
	logic                   level_q;
	logic                   previous_level_q;
	logic                   changed_q;

	logic                   a_high;
	logic                   b_high;
	logic                   active;
	logic                   raw;
	logic [COUNT_WIDTH-1:0] count_eff;
	logic [DWELL_W-1:0]     dwell;
	logic                   hit;

	assign a_high = CMP_W'(sample_a_s1) > CMP_W'(regs.threshold);
	assign b_high = CMP_W'(sample_b_s1) > CMP_W'(regs.threshold);

	always_comb begin
		case (regs.input_mode)
			MODE_SINGLE: begin
				active = 1'b1;
				raw    = a_high;
			end
			MODE_DUAL: begin
				active = 1'b1;
				raw    = a_high ^ b_high;
			end
			default: begin
				active = 1'b0;
				raw    = 1'b0;
			end
		endcase
	end

	assign count_eff = (last_raw_q != raw) ? '0 : count_q;
	assign dwell     = raw ? regs.high_dwell : regs.low_dwell;
	assign hit       = DCMP_W'(count_eff) == DCMP_W'(dwell);

	always_comb begin
		started_d         = started_q;
		last_raw_d        = last_raw_q;
		count_d           = count_q;
		accepted_d        = accepted_q;
		accepted_before_d = accepted_before_q;
		changed_d         = 1'b0;
		if (active) begin
			if (!started_q) begin
				started_d         = 1'b1;
				last_raw_d        = raw;
				accepted_d        = raw;
				accepted_before_d = raw;
			end else begin
				last_raw_d = raw;
				count_d    = (count_eff == COUNT_MAX) ? count_eff : count_eff + 1'b1;
				if (hit) begin
					accepted_before_d = accepted_q;
					accepted_d        = raw;
					changed_d         = 1'b1;
				end
			end
		end
	end

	assign take = valid_s1 && (!res_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q         <= 1'b0;
			last_raw_q        <= 1'b0;
			count_q           <= '0;
			accepted_q        <= 1'b0;
			accepted_before_q <= 1'b0;
			res_valid_q       <= 1'b0;
		end else begin
			if (take) begin
				started_q         <= started_d;
				last_raw_q        <= last_raw_d;
				count_q           <= count_d;
				accepted_q        <= accepted_d;
				accepted_before_q <= accepted_before_d;
				res_valid_q       <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			level_q          <= accepted_d;
			previous_level_q <= accepted_before_d;
			changed_q        <= changed_d;
		end
	end

	assign results.valid          = res_valid_q;
	assign results.level          = level_q;
	assign results.previous_level = previous_level_q;
	assign results.changed        = changed_q;

endmodule

### rtl/core/thresholded_input_debouncer_core.sv
// Top level of the thresholded input debouncer.
//
// Each transfer on the samples channel carries one tick of converter data
// (sample_a, and sample_b for dual mode). Every tick yields exactly one
// transfer on the results channel with the accepted level, the level before
// the latest acceptance and a change flag.
// The cfg channel writes the mode, threshold and dwell registers by index.
// It is always ready; it must be written only while the block is idle, a rule
// for the user that the block itself does not enforce. A tick passes an
// input register and then a result register before it reaches results.
// One tick is taken per cycle as long as the receiver takes results; the
// result register lets the next tick enter while the last result still waits.
// When the receiver stalls, the result holds and the input stage fills;
// sample ready then drops until the result is taken.
// Reset clears the debounce state; registers return to single mode,
// threshold 2048 and dwell counts of 10. The first active tick after reset
// adopts its level at once.
module thresholded_input_debouncer_core #(
	parameter int SAMPLE_WIDTH = tid_pkg::SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = tid_pkg::COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tid_cfg_if.sink      cfg,
	tid_sample_if.sink   samples,
	tid_result_if.source results
);
	import tid_pkg::*;

	tid_cfg_t                regs;
	logic                    take;
	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] sample_a_s1;
	logic [SAMPLE_WIDTH-1:0] sample_b_s1;

	tid_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tid_in_reg #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.take        (take),
		.valid_s1    (valid_s1),
		.sample_a_s1 (sample_a_s1),
		.sample_b_s1 (sample_b_s1)
	);

	tid_debounce #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.regs        (regs),
		.valid_s1    (valid_s1),
		.sample_a_s1 (sample_a_s1),
		.sample_b_s1 (sample_b_s1),
		.take        (take),
		.results     (results)
	);

endmodule

### dv/thresholded_input_debouncer_core_test.sv
// Self-checking testbench of the thresholded input debouncer core.
`timescale 1ns / 1ps

module thresholded_input_debouncer_core_test;
	import tid_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int CW = COUNT_WIDTH_DEF;
	localparam logic [MODE_W-1:0] MODE_OFF     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_OFF_ALT = 2'd3;
	localparam logic [SW-1:0] SAMPLE_MAX = '1;
	localparam int RANDOM_TICKS = 550;
	localparam int IDLE_LIMIT   = 5000;

	typedef struct {
		logic level;
		logic previous_level;
		logic changed;
	} debounce_out_t;

	class debounce_scoreboard;
		logic [MODE_W-1:0]  mode;
		logic [THR_W-1:0]   thr;
		logic [DWELL_W-1:0] low_dwell;
		logic [DWELL_W-1:0] high_dwell;
		bit                 started;
		logic               last_raw;
		logic [CW-1:0]      stable_cnt;
		logic               level_now;
		logic               level_before;
		debounce_out_t      expected_levels[$];
		int                 errors;

		function new();
			mode         = MODE_RESET;
			thr          = THR_RESET;
			low_dwell    = LOW_DWELL_RST;
			high_dwell   = HIGH_DWELL_RST;
			started      = 0;
			last_raw     = 0;
			stable_cnt   = '0;
			level_now    = 0;
			level_before = 0;
			errors       = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_INPUT_MODE: mode = val[MODE_W-1:0];
				REG_THRESHOLD:  thr = val[THR_W-1:0];
				REG_LOW_DWELL:  low_dwell = val[DWELL_W-1:0];
				REG_HIGH_DWELL: high_dwell = val[DWELL_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_tick(logic [SW-1:0] a, logic [SW-1:0] b);
			debounce_out_t      exp_out;
			logic               raw;
			logic [DWELL_W-1:0] dwell;
			exp_out.changed = 0;
			if (mode == MODE_SINGLE || mode == MODE_DUAL) begin
				raw = (a > thr);
				if (mode == MODE_DUAL)
					raw = raw ^ (b > thr);
				if (!started) begin
					started      = 1;
					last_raw     = raw;
					level_now    = raw;
					level_before = raw;
				end else begin
					if (last_raw != raw) begin
						stable_cnt = '0;
						last_raw   = raw;
					end
					dwell = raw ? high_dwell : low_dwell;
					if (stable_cnt == dwell) begin
						level_before    = level_now;
						level_now       = raw;
						exp_out.changed = 1;
					end
					if (stable_cnt != '1)
						stable_cnt++;
				end
			end
			exp_out.level          = level_now;
			exp_out.previous_level = level_before;
			expected_levels.push_back(exp_out);
		endfunction

		function void check_result(logic level, logic previous_level, logic changed);
			debounce_out_t exp_out;
			if (expected_levels.size() == 0) begin
				$error("unexpected result transfer: level %0d previous_level %0d changed %0d",
					level, previous_level, changed);
				errors++;
				return;
			end
			exp_out = expected_levels.pop_front();
			if (level !== exp_out.level) begin
				$error("level expected %0d actual %0d", exp_out.level, level);
				errors++;
			end
			if (previous_level !== exp_out.previous_level) begin
				$error("previous_level expected %0d actual %0d",
					exp_out.previous_level, previous_level);
				errors++;
			end
			if (changed !== exp_out.changed) begin
				$error("changed expected %0d actual %0d", exp_out.changed, changed);
				errors++;
			end
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tid_cfg_if                         cfg_ch ();
	tid_sample_if #(.SAMPLE_WIDTH(SW)) samp ();
	tid_result_if                      res ();

	thresholded_input_debouncer_core #(
		.SAMPLE_WIDTH(SW),
		.COUNT_WIDTH (CW)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.samples(samp),
		.results(res)
	);

	debounce_scoreboard sb = new();

	bit                 quiet;
	int                 stall_left;
	int                 idle_cycles;
	logic [MODE_W-1:0]  cur_mode;
	logic [THR_W-1:0]   cur_thr;
	logic [DWELL_W-1:0] cur_low;
	logic [DWELL_W-1:0] cur_high;

	initial begin
		clk            = 0;
		arst_n         = 0;
		cfg_ch.valid   = 0;
		cfg_ch.index   = '0;
		cfg_ch.data    = '0;
		samp.valid     = 0;
		samp.sample_a  = '0;
		samp.sample_b  = '0;
		res.ready      = 0;
		quiet          = 0;
		stall_left     = 0;
		idle_cycles    = 0;
	end

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (samp.valid && samp.ready)
				sb.note_tick(samp.sample_a, samp.sample_b);
			if (res.valid && res.ready)
				sb.check_result(res.level, res.previous_level, res.changed);
			if ((samp.valid && samp.ready) || (res.valid && res.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
			if (stall_left > 0) begin
				res.ready  <= 0;
				stall_left <= stall_left - 1;
			end else begin
				res.ready  <= 1;
				stall_left <= pick_gap();
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.write_reg(idx, val);
		case (idx)
			REG_INPUT_MODE: cur_mode = val[MODE_W-1:0];
			REG_THRESHOLD:  cur_thr = val[THR_W-1:0];
			REG_LOW_DWELL:  cur_low = val[DWELL_W-1:0];
			REG_HIGH_DWELL: cur_high = val[DWELL_W-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_tick(logic [SW-1:0] a, logic [SW-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			samp.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		samp.valid    <= 1;
		samp.sample_a <= a;
		samp.sample_b <= b;
		@(posedge clk);
		while (!samp.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		samp.valid <= 0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_all(logic [MODE_W-1:0] m, logic [THR_W-1:0] t,
		logic [DWELL_W-1:0] lo, logic [DWELL_W-1:0] hi);
		write_reg(REG_INPUT_MODE, CFG_DATA_W'(m));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(t));
		write_reg(REG_LOW_DWELL, lo);
		write_reg(REG_HIGH_DWELL, hi);
	endtask

	function automatic logic [SW-1:0] above_thr(logic [THR_W-1:0] t);
		if (t == SAMPLE_MAX)
			return SW'($urandom_range(0, 4095));
		return SW'(t + 1 + $urandom_range(0, 4094 - t));
	endfunction

	function automatic logic [SW-1:0] below_thr(logic [THR_W-1:0] t);
		return SW'($urandom_range(0, t));
	endfunction

	task automatic send_level(logic target);
		logic hi_a;
		logic hi_b;
		logic [SW-1:0] a;
		logic [SW-1:0] b;
		hi_a = 1'($urandom_range(0, 1));
		hi_b = 1'($urandom_range(0, 1));
		if (cur_mode == MODE_SINGLE)
			hi_a = target;
		else if (cur_mode == MODE_DUAL)
			hi_b = hi_a ^ target;
		a = hi_a ? above_thr(cur_thr) : below_thr(cur_thr);
		b = hi_b ? above_thr(cur_thr) : below_thr(cur_thr);
		send_tick(a, b);
	endtask

	function automatic logic [DWELL_W-1:0] pick_dwell();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 14)
			return '1;
		if (r < 18)
			return DWELL_W'($urandom_range(0, 65535));
		return DWELL_W'($urandom_range(1, 6));
	endfunction

	initial begin
		int            done_ticks;
		int            phase_ticks;
		int            run_len;
		int            r;
		logic          target;
		logic [MODE_W-1:0] m;
		logic [THR_W-1:0]  t;

		cur_mode = MODE_RESET;
		cur_thr  = THR_RESET;
		cur_low  = LOW_DWELL_RST;
		cur_high = HIGH_DWELL_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_tick(SAMPLE_MAX, '0);
		send_tick('0, SAMPLE_MAX);
		send_tick(12'd2048, '0);
		send_tick(12'd2049, '0);
		send_tick('0, '0);
		drain();

		write_reg(REG_LOW_DWELL, '0);
		write_reg(REG_HIGH_DWELL, '0);
		send_tick('0, '0);
		send_tick(SAMPLE_MAX, '0);
		send_tick(SAMPLE_MAX, SAMPLE_MAX);
		send_tick('0, SAMPLE_MAX);
		send_tick('0, '0);
		drain();

		write_reg(REG_INPUT_MODE, CFG_DATA_W'(MODE_DUAL));
		write_reg(REG_THRESHOLD, '0);
		send_tick(SAMPLE_MAX, SAMPLE_MAX);
		send_tick(SAMPLE_MAX, '0);
		send_tick('0, '0);
		send_tick('0, SAMPLE_MAX);
		send_tick(12'd1, '0);
		drain();

		write_reg(REG_INPUT_MODE, CFG_DATA_W'(MODE_SINGLE));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(SAMPLE_MAX));
		send_tick(SAMPLE_MAX, SAMPLE_MAX);
		send_tick(SAMPLE_MAX, '0);
		drain();

		write_reg(REG_INPUT_MODE, CFG_DATA_W'(MODE_OFF));
		write_reg(REG_THRESHOLD, '0);
		send_tick(SAMPLE_MAX, '0);
		send_tick('0, SAMPLE_MAX);
		drain();
		write_reg(REG_INPUT_MODE, CFG_DATA_W'(MODE_OFF_ALT));
		send_tick(SAMPLE_MAX, SAMPLE_MAX);
		drain();

		done_ticks = 0;
		while (done_ticks < RANDOM_TICKS) begin
			quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 45)
				m = MODE_SINGLE;
			else if (r < 85)
				m = MODE_DUAL;
			else if (r < 95)
				m = MODE_OFF;
			else
				m = MODE_OFF_ALT;
			r = $urandom_range(0, 99);
			if (r < 8)
				t = '0;
			else if (r < 16)
				t = SAMPLE_MAX;
			else
				t = THR_W'($urandom_range(0, 4095));
			set_all(m, t, pick_dwell(), pick_dwell());
			phase_ticks = $urandom_range(25, 60);
			while (phase_ticks > 0 && done_ticks < RANDOM_TICKS) begin
				if ($urandom_range(0, 99) < 15) begin
					send_tick(SW'($urandom_range(0, 4095)), SW'($urandom_range(0, 4095)));
					phase_ticks--;
					done_ticks++;
				end else begin
					target  = 1'($urandom_range(0, 1));
					run_len = (target ? cur_high : cur_low) + $urandom_range(1, 3);
					if (run_len > 40)
						run_len = $urandom_range(1, 40);
					for (int i = 0; i < run_len; i++)
						send_level(target);
					phase_ticks -= run_len;
					done_ticks  += run_len;
				end
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
